>>> hdl/lbr_pkg.sv
// shared types and constants of the lossy broadcast ring
package lbr_pkg;

    typedef enum logic [1:0] {
        KIND_SEND        = 2'd0,
        KIND_SUBSCRIBE   = 2'd1,
        KIND_UNSUBSCRIBE = 2'd2,
        KIND_RECEIVE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOT_SUB = 2'd2
    } t_status;

    localparam int unsigned RX_FIELD_W  = 3;
    localparam int unsigned MSG_W       = 64;
    localparam int unsigned LOST_W      = 31;
    localparam logic [LOST_W-1:0] LOST_MAX = {LOST_W{1'b1}};

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 96;

endpackage

>>> hdl/lossy_broadcast_ring_unit.sv
// lossy broadcast ring: one publisher, several receivers with private read cursors
//
// slave channel carries one request per beat: tuser holds the kind (send, subscribe,
// unsubscribe, receive), tdata holds the receiver index and the message word.
// master channel returns exactly one result beat per request, in order: tuser is the
// status (ok, nothing new, not subscribed), tdata holds the read data and the
// count of messages that were overwritten before the receiver got to them.
// a request is taken every cycle while the master side does not stall; a slave beat
// passes the input register, where the cursor read from the cursor memory comes back,
// then one pass of lag and slot logic into the result register, which also captures
// the registered read of the message memory.
// when the master side stalls, the result register holds, the input register fills,
// and then s_tready drops; no beat is dropped or repeated.
// reset clears the publish count, the active marks and both valid flags; the message
// and cursor memories are not cleared, a cursor is always written by its subscribe
// before it is used, and a slot is read only after a send wrote it.
module lossy_broadcast_ring_unit #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned RECEIVERS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [lbr_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // receiver[2:0], message[66:3], zero pad
    input  logic [1:0]               i_s_axis_tuser,  // kind[1:0]
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [lbr_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // read_data[63:0], lost_count[94:64], pad
    output logic [1:0]               o_m_axis_tuser   // status[1:0]
);
    import lbr_pkg::*;

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned RX_W = (RECEIVERS > 1) ? $clog2(RECEIVERS) : 1;
    localparam logic [MSG_W-1:0] CAP_W = MSG_W'(CAPACITY);

    // storage
    logic [MSG_W-1:0] r_slot_mem   [CAPACITY];
    logic [MSG_W-1:0] r_cursor_mem [RECEIVERS];
    logic [RECEIVERS-1:0] r_active;
    logic [MSG_W-1:0] r_pub;

    // input register
    logic                  r_a_valid;
    t_kind                 r_a_kind;
    logic [RX_FIELD_W-1:0] r_a_rx;
    logic [MSG_W-1:0]      r_a_msg;
    logic [MSG_W-1:0]      r_a_cur_q;    // registered cursor memory read
    logic                  r_a_byp;      // cursor was rewritten at the read edge
    logic [MSG_W-1:0]      r_a_byp_cur;

    // result register
    logic                  r_b_valid;
    t_status               r_b_status;
    logic [LOST_W-1:0]     r_b_lost;
    logic                  r_b_has_data;
    logic [MSG_W-1:0]      r_rd;

    logic                  acc;
    logic                  adv;
    logic [RX_FIELD_W-1:0] in_rx;
    logic [RX_W-1:0]       in_idx;
    logic [RX_W-1:0]       a_idx;
    logic                  a_in_range;
    logic                  a_active;
    logic [MSG_W-1:0]      a_cur;
    logic [MSG_W-1:0]      a_lag;
    logic [MSG_W-1:0]      a_lost_full;
    logic                  a_over;
    logic                  a_caught;
    logic [LOST_W-1:0]     a_lost;
    logic [AW-1:0]         a_rd_addr;
    logic                  a_do_read;
    logic                  a_cur_wr;
    logic [MSG_W-1:0]      a_cur_wr_val;
    t_status               a_status;

    assign in_rx  = i_s_axis_tdata[RX_FIELD_W-1:0];
    assign in_idx = RX_W'(in_rx);

    // pipeline moves when the result register is free or being drained
    assign adv = r_a_valid && (!r_b_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_a_valid || adv;
    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    // single pass over the item in the input register
    always_comb begin
        a_idx       = RX_W'(r_a_rx);
        a_in_range  = (32'(r_a_rx) < RECEIVERS);
        a_active    = r_active[a_idx];
        a_cur       = r_a_byp ? r_a_byp_cur : r_a_cur_q;
        a_lag       = r_pub - a_cur;               // modulo 2^64
        a_caught    = (a_lag == '0);
        a_over      = (a_lag > CAP_W);
        a_lost_full = a_lag - CAP_W;
        if (!a_over) begin
            a_lost = '0;
        end else if (|a_lost_full[MSG_W-1:LOST_W]) begin
            a_lost = LOST_MAX;
        end else begin
            a_lost = a_lost_full[LOST_W-1:0];
        end
        // after a jump the oldest live slot is publish_count - capacity, same low bits
        a_rd_addr    = a_over ? r_pub[AW-1:0] : a_cur[AW-1:0];
        a_do_read    = 1'b0;
        a_cur_wr     = 1'b0;
        a_cur_wr_val = a_over ? (r_pub - CAP_W + MSG_W'(1)) : (a_cur + MSG_W'(1));
        a_status     = ST_OK;
        unique case (r_a_kind)
            KIND_SEND: begin
                a_status = ST_OK;
            end
            KIND_SUBSCRIBE: begin
                a_status     = a_in_range ? ST_OK : ST_NOT_SUB;
                a_cur_wr     = a_in_range;
                a_cur_wr_val = r_pub;
            end
            KIND_UNSUBSCRIBE: begin
                a_status = a_in_range ? ST_OK : ST_NOT_SUB;
            end
            KIND_RECEIVE: begin
                if (!a_in_range || !a_active) begin
                    a_status = ST_NOT_SUB;
                end else if (a_caught) begin
                    a_status = ST_EMPTY;
                end else begin
                    a_status  = ST_OK;
                    a_do_read = 1'b1;
                    a_cur_wr  = 1'b1;
                end
            end
            default: a_status = ST_OK;
        endcase
    end

    // message memory: written by a send, read with registered data by a receive
    always_ff @(posedge i_clk) begin
        if (adv && r_a_kind == KIND_SEND) begin
            r_slot_mem[r_pub[AW-1:0]] <= r_a_msg;
        end
        if (adv && a_do_read) begin
            r_rd <= r_slot_mem[a_rd_addr];
        end
    end

    // cursor memory: read when a beat is taken, written when an item leaves stage a
    always_ff @(posedge i_clk) begin
        if (adv && a_cur_wr) begin
            r_cursor_mem[a_idx] <= a_cur_wr_val;
        end
        if (acc) begin
            r_a_cur_q <= r_cursor_mem[in_idx];
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_kind    <= t_kind'(i_s_axis_tuser);
            r_a_rx      <= in_rx;
            r_a_msg     <= i_s_axis_tdata[RX_FIELD_W +: MSG_W];
            r_a_byp     <= adv && a_cur_wr && (r_a_rx == in_rx);
            r_a_byp_cur <= a_cur_wr_val;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_status   <= a_status;
            r_b_lost     <= a_do_read ? a_lost : '0;
            r_b_has_data <= a_do_read;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_pub     <= '0;
            r_active  <= '0;
        end else begin
            if (acc) begin
                r_a_valid <= 1'b1;
            end else if (adv) begin
                r_a_valid <= 1'b0;
            end
            if (adv) begin
                r_b_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_b_valid <= 1'b0;
            end
            if (adv && r_a_kind == KIND_SEND) begin
                r_pub <= r_pub + MSG_W'(1);
            end
            if (adv && a_in_range && r_a_kind == KIND_SUBSCRIBE) begin
                r_active[a_idx] <= 1'b1;
            end
            if (adv && a_in_range && r_a_kind == KIND_UNSUBSCRIBE) begin
                r_active[a_idx] <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_b_valid;
    assign o_m_axis_tuser  = r_b_status;
    assign o_m_axis_tdata  = {1'b0, r_b_lost, (r_b_has_data ? r_rd : {MSG_W{1'b0}})};

`ifndef SYNTHESIS
    // only a successful receive carries data or a loss count
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_status != ST_OK |-> !r_b_has_data && r_b_lost == '0)
        else $error("non-ok result carries data or loss count");

    // each send that leaves stage a bumps the publish count by one
    a_pub_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_a_kind == KIND_SEND |=> r_pub == $past(r_pub) + MSG_W'(1))
        else $error("publish count did not advance on send");

    // publish count never moves without a send
    a_pub_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv && r_a_kind == KIND_SEND) |=> $stable(r_pub))
        else $error("publish count moved without a send");

    // a stalled result register keeps its content
    a_hold_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !i_m_axis_tready |=> r_b_valid && $stable(r_b_status)
            && $stable(r_b_lost) && $stable(r_b_has_data))
        else $error("result register changed while stalled");
`endif

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the lossy broadcast ring unit
module testbench;
    import lbr_pkg::*;

    // block sizes, kept equal to the instance parameters below
    localparam int unsigned RING_SLOTS = 16;
    localparam int unsigned RX_COUNT   = 8;

    // one result beat as the master side returns it
    typedef struct {
        t_status             status;
        logic [MSG_W-1:0]    data;
        logic [LOST_W-1:0]   lost;
    } t_reply;

    // shadow of the ring: works out the reply of every accepted request and
    // compares the reply beats, in order, against it
    class broadcast_ring_checker;
        logic [MSG_W-1:0] slot_words [RING_SLOTS];
        logic [63:0]      publish_total;
        logic [63:0]      rx_cursor [RX_COUNT];
        bit               rx_active [RX_COUNT];
        t_reply           pending_replies [$];
        int               mismatches;
        int               replies_seen;
        int               reads_ok;
        int               reads_lossy;
        int               reads_empty;
        int               reads_unsubscribed;

        function new();
            publish_total = '0;
            foreach (slot_words[i]) slot_words[i] = '0;
            foreach (rx_cursor[i]) rx_cursor[i] = '0;
            foreach (rx_active[i]) rx_active[i] = 1'b0;
            mismatches = 0;
            replies_seen = 0;
            reads_ok = 0;
            reads_lossy = 0;
            reads_empty = 0;
            reads_unsubscribed = 0;
        endfunction

        function void note_request(t_kind kind, logic [RX_FIELD_W-1:0] rx,
                                   logic [MSG_W-1:0] msg);
            t_reply      rep;
            logic [63:0] lag;
            logic [63:0] skipped;
            rep.status = ST_OK;
            rep.data   = '0;
            rep.lost   = '0;
            case (kind)
                KIND_SEND: begin
                    slot_words[publish_total % RING_SLOTS] = msg;
                    publish_total++;
                end
                KIND_SUBSCRIBE: begin
                    if (rx < RX_COUNT) begin
                        rx_cursor[rx] = publish_total;
                        rx_active[rx] = 1'b1;
                    end else begin
                        rep.status = ST_NOT_SUB;
                    end
                end
                KIND_UNSUBSCRIBE: begin
                    if (rx < RX_COUNT) rx_active[rx] = 1'b0;
                    else rep.status = ST_NOT_SUB;
                end
                default: begin
                    if (rx >= RX_COUNT || !rx_active[rx]) begin
                        rep.status = ST_NOT_SUB;
                        reads_unsubscribed++;
                    end else begin
                        lag = publish_total - rx_cursor[rx];
                        if (lag == 0) begin
                            rep.status = ST_EMPTY;
                            reads_empty++;
                        end else begin
                            // fell behind the ring: skip to the oldest live slot
                            if (lag > RING_SLOTS) begin
                                skipped = lag - RING_SLOTS;
                                rep.lost = (skipped > LOST_MAX) ? LOST_MAX
                                                                : skipped[LOST_W-1:0];
                                rx_cursor[rx] = publish_total - RING_SLOTS;
                                reads_lossy++;
                            end
                            rep.data = slot_words[rx_cursor[rx] % RING_SLOTS];
                            rx_cursor[rx]++;
                            reads_ok++;
                        end
                    end
                end
            endcase
            pending_replies.push_back(rep);
        endfunction

        function void check_reply(logic [1:0] status, logic [MSG_W-1:0] data,
                                  logic [LOST_W-1:0] lost);
            t_reply want;
            replies_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: reply beat with nothing outstanding, status %0d",
                             status);
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status || data !== want.data || lost !== want.lost) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on reply %0d: status %0d/%0d data %h/%h lost %0d/%0d",
                             replies_seen, want.status, status, want.data, data,
                             want.lost, lost);
            end
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data;   // receiver[2:0], message[66:3], zero pad
    t_kind                 s_kind;   // kind[1:0]
    logic                  m_valid;
    logic                  m_ready;
    logic [M_TDATA_W-1:0]  m_data;   // read_data[63:0], lost_count[94:64], pad
    logic [1:0]            m_status; // status[1:0]

    broadcast_ring_checker ring_check;

    // generator-side view of which receivers are subscribed, used to aim receives
    bit [RX_COUNT-1:0] gen_active;
    int                burst_left;
    int                requests_sent;

    lossy_broadcast_ring_unit #(
        .CAPACITY  (RING_SLOTS),
        .RECEIVERS (RX_COUNT)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // both channels are sampled at the edge, before any of this step's drives land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready)
                ring_check.note_request(s_kind, s_data[RX_FIELD_W-1:0],
                                        s_data[RX_FIELD_W +: MSG_W]);
            if (m_valid && m_ready)
                ring_check.check_reply(m_status, m_data[MSG_W-1:0],
                                       m_data[MSG_W +: LOST_W]);
        end
    end

    // result side: the stall pattern steps through phases of steady and random ready; two long hold-offs
    // let the input register fill so that s_tready has to drop while the
    // sender keeps offering beats
    initial begin
        int cyc;
        m_ready <= 1'b0;
        cyc = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            cyc++;
            if ((cyc >= 300 && cyc < 380) || (cyc >= 1500 && cyc < 1560)) begin
                m_ready <= 1'b0;
            end else begin
                case ((cyc / 64) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
            @(posedge i_clk);
        end
    end

    // offer one request beat and hold it until the block takes it; between
    // bursts valid may drop for a random gap, inside a burst it stays high
    task automatic issue(t_kind kind, logic [RX_FIELD_W-1:0] rx, logic [MSG_W-1:0] msg);
        int gap;
        if (kind == KIND_SUBSCRIBE) gen_active[rx] = 1'b1;
        if (kind == KIND_UNSUBSCRIBE) gen_active[rx] = 1'b0;
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= {{(S_TDATA_W - MSG_W - RX_FIELD_W){1'b0}}, msg, rx};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [MSG_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // receiver for a receive: mostly a subscribed one, so reads get past the
    // not-subscribed answer
    function automatic logic [RX_FIELD_W-1:0] pick_reader();
        logic [RX_FIELD_W-1:0] rx;
        rx = RX_FIELD_W'($urandom_range(0, RX_COUNT - 1));
        if (gen_active != '0 && $urandom_range(0, 99) < 85)
            while (!gen_active[rx]) rx = RX_FIELD_W'($urandom_range(0, RX_COUNT - 1));
        return rx;
    endfunction

    initial begin
        int seg_len;
        int pick;
        int waited;
        ring_check    = new();
        gen_active    = '0;
        burst_left    = 3;
        requests_sent = 0;
        i_rst_n  <= 1'b0;
        s_valid  <= 1'b0;
        s_kind   <= KIND_SEND;
        s_data   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: not-subscribed answers, empty read, extreme words,
        // resubscribe, and an overrun that reports lost messages
        issue(KIND_RECEIVE, 3'd3, '0);
        issue(KIND_UNSUBSCRIBE, 3'd3, '0);
        issue(KIND_SUBSCRIBE, 3'd0, '0);
        issue(KIND_RECEIVE, 3'd0, '0);
        issue(KIND_SEND, 3'd7, {MSG_W{1'b1}});
        issue(KIND_SEND, 3'd0, '0);
        issue(KIND_RECEIVE, 3'd0, '0);
        issue(KIND_SUBSCRIBE, 3'd7, '0);
        issue(KIND_SUBSCRIBE, 3'd7, '0);
        issue(KIND_RECEIVE, 3'd7, '0);
        // seventeen sends leave receiver 0 two behind the ring and receiver 7 one
        for (int i = 0; i < 17; i++)
            issue(KIND_SEND, 3'(i), 64'h1 << (i * 4 + 1));
        issue(KIND_RECEIVE, 3'd0, '0);
        issue(KIND_RECEIVE, 3'd7, '0);
        issue(KIND_UNSUBSCRIBE, 3'd0, '0);
        issue(KIND_RECEIVE, 3'd0, '0);

        // random segments: floods that overrun readers, ordinary traffic
        // aimed at subscribed receivers, and plain noise
        while (requests_sent < 430) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                seg_len = $urandom_range(17, 40);
                repeat (seg_len) issue(KIND_SEND, 3'($urandom), random_word());
            end else if (pick == 2) begin
                seg_len = $urandom_range(5, 15);
                repeat (seg_len)
                    issue(t_kind'($urandom_range(0, 3)), 3'($urandom), random_word());
            end else begin
                seg_len = $urandom_range(10, 30);
                repeat (seg_len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        issue(KIND_SEND, 3'($urandom), random_word());
                    else if (pick < 45)
                        issue(KIND_SUBSCRIBE, 3'($urandom), random_word());
                    else if (pick < 52)
                        issue(KIND_UNSUBSCRIBE, 3'($urandom), random_word());
                    else
                        issue(KIND_RECEIVE, pick_reader(), random_word());
                end
            end
        end
        s_valid <= 1'b0;

        // drain, then keep watching for stray reply beats
        waited = 0;
        while (ring_check.outstanding() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);

        $display("requests %0d, replies %0d: %0d reads with data (%0d after overrun),",
                 requests_sent, ring_check.replies_seen, ring_check.reads_ok,
                 ring_check.reads_lossy);
        $display("%0d empty, %0d unsubscribed, mismatches %0d, still outstanding %0d",
                 ring_check.reads_empty, ring_check.reads_unsubscribed,
                 ring_check.mismatches, ring_check.outstanding());
        if (ring_check.mismatches == 0 && ring_check.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
